// ----- hdl/grehpc_pkg.sv -----
// Types and constants for the GRE header parse and check unit.
`default_nettype none

package grehpc_pkg;

    localparam int DEF_MAX_PACKET_BYTES = 65535;

    // GRE flag word bits
    localparam logic [15:0] FLAG_CSUM    = 16'h8000;
    localparam logic [15:0] FLAG_ROUTING = 16'h4000;
    localparam logic [15:0] FLAG_KEY     = 16'h2000;
    localparam logic [15:0] FLAG_SEQ     = 16'h1000;
    localparam logic [15:0] FLAG_VERSION = 16'h0007;

    localparam logic [15:0] SUM_GOOD = 16'hffff;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT     = 2'd1;
    localparam logic [1:0] STATUS_BAD_FLAGS = 2'd2;
    localparam logic [1:0] STATUS_CSUM_ERR  = 2'd3;

    localparam logic [4:0] BASE_HDR_LEN = 5'd4;
    localparam logic [4:0] OPT_WORD_LEN = 5'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] protocol;
        logic [31:0] tunnel_key;
        logic [31:0] sequence_number;
        logic [4:0]  header_length;
        logic [15:0] gre_flags;
    } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/gre_header_parse_check_unit.sv -----
// GRE header parser and checker: per-byte field capture, checksum and result register.
//
//   channel | dir | payload    | handshake
//   s_      | in  | in_item_t  | s_valid / s_ready, one packet byte per item
//   m_      | out | out_item_t | m_valid / m_ready, one result per packet
//
// One byte per cycle sustained while no staged last byte is held back: a byte is staged in the input register,
// then a single pass of field capture and a one's-complement add updates state.
// The result shows on m_ the cycle after the last byte leaves the input register.
// aresetn (synchronous) clears the counters, sum, captured fields and valids.
// Non-last bytes keep flowing while a result waits on m_ready; only a staged
// last byte waits for the result register to free up.
`default_nettype none

module gre_header_parse_check_unit
    import grehpc_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PACKET_BYTES);

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [4:0] hdr_len(input logic [15:0] f);
        logic [4:0] h;
        h = BASE_HDR_LEN;
        if ((f & FLAG_CSUM) != 16'h0) h = h + OPT_WORD_LEN;
        if ((f & FLAG_KEY) != 16'h0)  h = h + OPT_WORD_LEN;
        if ((f & FLAG_SEQ) != 16'h0)  h = h + OPT_WORD_LEN;
        return h;
    endfunction

    logic            in_valid_reg, in_valid_next;
    in_item_t        in_item_reg;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_item_reg, m_item_next;

    logic [CW-1:0]   count_reg, count_next;
    logic [15:0]     sum_reg, sum_next;
    logic [7:0]      pend_reg, pend_next;
    logic [15:0]     flags_reg, flags_next;
    logic [15:0]     proto_reg, proto_next;
    logic [31:0]     key_reg, key_next;
    logic [31:0]     seq_reg, seq_next;

    logic            stage_fire;
    logic            taken;
    logic            odd;
    logic [7:0]      b;
    logic [15:0]     sum_word;
    logic [15:0]     sum_total;
    logic [4:0]      key_off;
    logic [4:0]      seq_off;
    logic [4:0]      hlen;

    assign stage_fire = in_valid_reg && (!in_item_reg.last_byte || !m_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || stage_fire;
    assign m_valid    = m_valid_reg;
    assign m_item     = m_item_reg;

    assign b     = in_item_reg.data_byte;
    assign taken = count_reg < COUNT_MAX;
    assign odd   = count_reg[0];

    // one add covers both the running sum and the padded odd tail at the end
    always_comb begin
        if (taken) begin
            sum_word = odd ? {pend_reg, b} : {b, 8'h00};
        end else begin
            sum_word = odd ? {pend_reg, 8'h00} : 16'h0000;
        end
    end
    assign sum_total = oc_add(sum_reg, sum_word);

    assign key_off = ((flags_reg & FLAG_CSUM) != 16'h0) ? BASE_HDR_LEN + OPT_WORD_LEN
                                                         : BASE_HDR_LEN;
    assign seq_off = ((flags_reg & FLAG_KEY) != 16'h0) ? key_off + OPT_WORD_LEN : key_off;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        flags_next = flags_reg;
        proto_next = proto_reg;
        key_next   = key_reg;
        seq_next   = seq_reg;
        if (taken) begin
            count_next = count_reg + 1'b1;
            if (odd) begin
                sum_next = sum_total;
            end else begin
                pend_next = b;
            end
            if (count_reg == CW'(0)) begin
                flags_next = {b, 8'h00};
            end else if (count_reg == CW'(1)) begin
                flags_next = {flags_reg[15:8], b};
            end else if (count_reg == CW'(2)) begin
                proto_next = {b, 8'h00};
            end else if (count_reg == CW'(3)) begin
                proto_next = {proto_reg[15:8], b};
            end else begin
                if ((flags_reg & FLAG_KEY) != 16'h0 && count_reg >= CW'(key_off)
                        && count_reg < CW'(key_off + OPT_WORD_LEN)) begin
                    key_next = {key_reg[23:0], b};
                end
                if ((flags_reg & FLAG_SEQ) != 16'h0 && count_reg >= CW'(seq_off)
                        && count_reg < CW'(seq_off + OPT_WORD_LEN)) begin
                    seq_next = {seq_reg[23:0], b};
                end
            end
        end
    end

    assign hlen = hdr_len(flags_next);

    always_comb begin
        m_item_next                 = '0;
        m_item_next.gre_flags       = flags_next;
        if (count_next < CW'(4)) begin
            m_item_next.status = STATUS_SHORT;
        end else if ((flags_next & (FLAG_VERSION | FLAG_ROUTING)) != 16'h0) begin
            m_item_next.status   = STATUS_BAD_FLAGS;
            m_item_next.protocol = proto_next;
        end else if (count_next < CW'(hlen)) begin
            m_item_next.status = STATUS_SHORT;
        end else if ((flags_next & FLAG_CSUM) != 16'h0 && sum_total != SUM_GOOD) begin
            m_item_next.status   = STATUS_CSUM_ERR;
            m_item_next.protocol = proto_next;
        end else begin
            m_item_next.status        = STATUS_OK;
            m_item_next.protocol      = proto_next;
            m_item_next.header_length = hlen;
            if ((flags_next & FLAG_KEY) != 16'h0) m_item_next.tunnel_key = key_next;
            if ((flags_next & FLAG_SEQ) != 16'h0) m_item_next.sequence_number = seq_next;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (stage_fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (stage_fire && in_item_reg.last_byte) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (stage_fire && in_item_reg.last_byte) begin
            m_item_reg <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            pend_reg     <= '0;
            flags_reg    <= '0;
            proto_reg    <= '0;
            key_reg      <= '0;
            seq_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (stage_fire) begin
                if (in_item_reg.last_byte) begin
                    // packet done: start clean for the next one
                    count_reg <= '0;
                    sum_reg   <= '0;
                    pend_reg  <= '0;
                    flags_reg <= '0;
                    proto_reg <= '0;
                    key_reg   <= '0;
                    seq_reg   <= '0;
                end else begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                    pend_reg  <= pend_next;
                    flags_reg <= flags_next;
                    proto_reg <= proto_next;
                    key_reg   <= key_next;
                    seq_reg   <= seq_next;
                end
            end
        end
    end

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_fire && in_item_reg.last_byte) |=> (count_reg == '0 && sum_reg == '0))
        else $error("packet state not cleared after last item");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("byte count beyond packet limit");

    a_stall_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_item_reg.last_byte && m_valid_reg && !m_ready))
        else $error("input stalled without a waiting last item");

    a_ok_has_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == STATUS_OK) |-> (m_item.header_length >= BASE_HDR_LEN))
        else $error("ok result without header length");

    a_err_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status != STATUS_OK) |->
            (m_item.header_length == 5'd0 && m_item.tunnel_key == 32'd0))
        else $error("error result carries header fields");

    a_short_no_proto: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == STATUS_SHORT) |-> (m_item.protocol == 16'd0))
        else $error("short packet reports a protocol");
`endif

endmodule

`default_nettype wire

// ----- bench/gre_header_parse_check_tb_pkg.sv -----
// Result scoreboard and field predictor for the GRE header parse and check testbench.
package gre_header_parse_check_tb_pkg;
    import grehpc_pkg::*;

    // 16-bit one's-complement add with end-around carry
    function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    class gre_result_scoreboard;
        int unsigned pkt_bytes;
        logic [15:0] run_sum;
        logic [7:0]  high_byte;
        logic [15:0] flag_bits;
        logic [15:0] proto_bits;
        logic [31:0] key_bits;
        logic [31:0] seq_bits;
        out_item_t   expected_q[$];
        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned bytes_noted;

        function new();
            clear_packet();
            mismatches = 0;
            results_checked = 0;
            bytes_noted = 0;
        endfunction

        function void clear_packet();
            pkt_bytes = 0;
            run_sum = '0;
            high_byte = '0;
            flag_bits = '0;
            proto_bits = '0;
            key_bits = '0;
            seq_bits = '0;
        endfunction

        function int unsigned header_bytes(logic [15:0] f);
            int unsigned h;
            h = BASE_HDR_LEN;
            if ((f & FLAG_CSUM) != 0) h += OPT_WORD_LEN;
            if ((f & FLAG_KEY) != 0) h += OPT_WORD_LEN;
            if ((f & FLAG_SEQ) != 0) h += OPT_WORD_LEN;
            return h;
        endfunction

        function void capture_byte(logic [7:0] b);
            int unsigned off;
            if (pkt_bytes[0]) run_sum = ones_add(run_sum, {high_byte, b});
            else high_byte = b;
            case (pkt_bytes)
                0: flag_bits = {b, 8'h00};
                1: flag_bits[7:0] = b;
                2: proto_bits = {b, 8'h00};
                3: proto_bits[7:0] = b;
                default: begin
                    // checksum word, when present, sits ahead of key and sequence
                    off = BASE_HDR_LEN;
                    if ((flag_bits & FLAG_CSUM) != 0) off += OPT_WORD_LEN;
                    if ((flag_bits & FLAG_KEY) != 0) begin
                        if (pkt_bytes >= off && pkt_bytes < off + 4)
                            key_bits = {key_bits[23:0], b};
                        off += OPT_WORD_LEN;
                    end
                    if ((flag_bits & FLAG_SEQ) != 0 && pkt_bytes >= off && pkt_bytes < off + 4)
                        seq_bits = {seq_bits[23:0], b};
                end
            endcase
            pkt_bytes++;
        endfunction

        function void close_packet();
            out_item_t   exp;
            logic [15:0] sum;
            sum = run_sum;
            if (pkt_bytes[0]) sum = ones_add(sum, {high_byte, 8'h00});
            exp = '0;
            exp.gre_flags = flag_bits;
            if (pkt_bytes < 4) begin
                exp.status = STATUS_SHORT;
            end else if ((flag_bits & (FLAG_VERSION | FLAG_ROUTING)) != 0) begin
                exp.status = STATUS_BAD_FLAGS;
                exp.protocol = proto_bits;
            end else if (pkt_bytes < header_bytes(flag_bits)) begin
                exp.status = STATUS_SHORT;
            end else if ((flag_bits & FLAG_CSUM) != 0 && sum != SUM_GOOD) begin
                exp.status = STATUS_CSUM_ERR;
                exp.protocol = proto_bits;
            end else begin
                exp.status = STATUS_OK;
                exp.protocol = proto_bits;
                exp.header_length = 5'(header_bytes(flag_bits));
                if ((flag_bits & FLAG_KEY) != 0) exp.tunnel_key = key_bits;
                if ((flag_bits & FLAG_SEQ) != 0) exp.sequence_number = seq_bits;
            end
            expected_q.push_back(exp);
            clear_packet();
        endfunction

        function void note_byte(in_item_t it);
            bytes_noted++;
            // bytes past the size limit are dropped, but their last mark still counts
            if (pkt_bytes < DEF_MAX_PACKET_BYTES) capture_byte(it.data_byte);
            if (it.last_byte) close_packet();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, got %p", $time, got);
                mismatches++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("status", exp.status, got.status);
            compare_field("protocol", exp.protocol, got.protocol);
            compare_field("tunnel_key", exp.tunnel_key, got.tunnel_key);
            compare_field("sequence_number", exp.sequence_number, got.sequence_number);
            compare_field("header_length", exp.header_length, got.header_length);
            compare_field("gre_flags", exp.gre_flags, got.gre_flags);
            results_checked++;
        endfunction
    endclass

endpackage

// ----- bench/gre_header_parse_check_unit_tb.sv -----
// Testbench top: drives GRE packets byte by byte and checks every parse result.
module gre_header_parse_check_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import grehpc_pkg::*;
    import gre_header_parse_check_tb_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_BYTES = 2000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    gre_result_scoreboard sb = new();

    logic [7:0] pkt[$];
    int burst_left = 0;
    int packets_sent = 0;
    int random_bytes = 0;
    int cycle_count = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_phase = 0;

    gre_header_parse_check_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // sample at the edge, before the block's own updates land
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_item);
            if (m_valid && m_ready) sb.check_result(m_item);
        end
    end

    // receiver stalls: modes switch every so often
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(64, 256);
        end
        rx_mode_left--;
        rx_phase = (rx_phase + 1) % 21;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_phase == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 48);
        end
        s_item <= '{data_byte: b, last_byte: last};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    task automatic fill_bytes(input int len, input logic [7:0] val);
        pkt.delete();
        repeat (len) pkt.push_back(val);
    endtask

    // well-formed packet with random content; checksum patched when its flag is set
    task automatic make_gre(input logic [15:0] flags, input int pay_len);
        logic [15:0] acc;
        logic [15:0] w;
        int          opt_bytes;
        pkt.delete();
        pkt.push_back(flags[15:8]);
        pkt.push_back(flags[7:0]);
        repeat (2) pkt.push_back(8'($urandom));
        opt_bytes = 0;
        if ((flags & FLAG_KEY) != 0) opt_bytes += 4;
        if ((flags & FLAG_SEQ) != 0) opt_bytes += 4;
        if ((flags & FLAG_CSUM) != 0) begin
            pkt.push_back(8'h00);
            pkt.push_back(8'h00);
            repeat (2) pkt.push_back(8'($urandom));
        end
        repeat (opt_bytes + pay_len) pkt.push_back(8'($urandom));
        if ((flags & FLAG_CSUM) != 0) begin
            acc = '0;
            for (int i = 0; i < pkt.size(); i += 2) begin
                w = {pkt[i], (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00};
                acc = ones_add(acc, w);
            end
            acc = ~acc;
            pkt[4] = acc[15:8];
            pkt[5] = acc[7:0];
        end
    endtask

    initial begin
        logic [15:0] flags;
        int          kind;
        int          hlen;
        int          new_len;
        int          idx;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: tiny packets, extremes, several flag combinations and each error path
        fill_bytes(1, 8'hff);
        send_packet();
        fill_bytes(2, 8'h00);
        send_packet();
        fill_bytes(3, 8'hff);
        send_packet();
        make_gre(16'h0000, 0);
        pkt[2] = 8'hff;
        pkt[3] = 8'hff;
        send_packet();
        make_gre(FLAG_CSUM | FLAG_KEY | FLAG_SEQ, 7);
        send_packet();
        make_gre(FLAG_CSUM | FLAG_KEY | FLAG_SEQ, 6);
        pkt[pkt.size() - 1] ^= 8'h01;
        send_packet();
        make_gre(FLAG_CSUM, 0);
        send_packet();
        make_gre(FLAG_CSUM, 1);
        send_packet();
        make_gre(FLAG_VERSION, 2);
        send_packet();
        make_gre(FLAG_ROUTING | FLAG_KEY, 4);
        send_packet();
        make_gre(FLAG_KEY, 0);
        repeat (2) void'(pkt.pop_back());
        send_packet();
        make_gre(FLAG_KEY | FLAG_SEQ, 3);
        for (int i = 4; i < 12; i++) pkt[i] = 8'hff;
        send_packet();
        fill_bytes(20, 8'hff);
        send_packet();
        fill_bytes(16, 8'h00);
        send_packet();

        while (random_bytes < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            flags = 16'($urandom) & ~(FLAG_ROUTING | FLAG_VERSION);
            if (kind < 60) begin
                make_gre(flags, $urandom_range(0, 24));
            end else if (kind < 70) begin
                make_gre(flags | FLAG_CSUM, $urandom_range(0, 24));
                idx = $urandom_range(2, pkt.size() - 1);
                pkt[idx] ^= 8'(1 << $urandom_range(0, 7));
            end else if (kind < 78) begin
                make_gre(flags, $urandom_range(0, 12));
                if ($urandom_range(0, 1) == 0) pkt[0] |= FLAG_ROUTING[15:8];
                else pkt[1] |= 8'($urandom_range(1, 7));
            end else if (kind < 88) begin
                if ((flags & (FLAG_CSUM | FLAG_KEY | FLAG_SEQ)) == 0) flags |= FLAG_SEQ;
                make_gre(flags, $urandom_range(0, 8));
                hlen = 4;
                if ((flags & FLAG_CSUM) != 0) hlen += 4;
                if ((flags & FLAG_KEY) != 0) hlen += 4;
                if ((flags & FLAG_SEQ) != 0) hlen += 4;
                new_len = $urandom_range(4, hlen - 1);
                while (pkt.size() > new_len) void'(pkt.pop_back());
            end else if (kind < 93) begin
                pkt.delete();
                repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            end else begin
                pkt.delete();
                repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
            end
            random_bytes += pkt.size();
            send_packet();
        end

        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d packets (%0d bytes), %0d results checked", packets_sent,
                 sb.bytes_noted, sb.results_checked);
        $display("covered short, bad-flag, truncated, checksum and odd-length packets");
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- gre_header_parse_check_unit.f -----
hdl/grehpc_pkg.sv
hdl/gre_header_parse_check_unit.sv
bench/gre_header_parse_check_tb_pkg.sv
bench/gre_header_parse_check_unit_tb.sv
